FILE: sv/rcac_pkg.sv
// ----------------------------------------------------------------------------
// rcac_pkg - shared types and constants of the RC ADC result conditioner
// Holds the command codes, controller states and controller/datapath links.
// ----------------------------------------------------------------------------
package rcac_pkg;

  // Command codes carried in func
  typedef enum logic [1:0] {
    FUNC_SAMPLE    = 2'd0,
    FUNC_READ      = 2'd1,
    FUNC_CAL_START = 2'd2,
    FUNC_CAL_END   = 2'd3
  } func_e;

  // Configuration register indexes
  localparam logic CFG_ZERO_OFFSET = 1'b0;
  localparam logic CFG_HYST_BAND   = 1'b1;

  localparam logic [11:0] ZERO_OFFSET_RESET = 12'd80;
  localparam logic [7:0]  HYST_BAND_RESET   = 8'd2;
  localparam logic [15:0] FULL_SCALE_RESET  = 16'd4347;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SCALE,
    ST_DIV,
    ST_HYST,
    ST_OUT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the item, write history
    logic sum_step;  // add one history entry
    logic clip;      // average, offset, clip/raise full-scale
    logic div_start; // prepare divider
    logic div_step;  // one restoring division step
    logic hyst;      // apply hysteresis, update held result
    logic cal_start;
    logic cal_end;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sum_done;
    logic div_done;
  } status_t;

endpackage

FILE: sv/rcac_datapath.sv
// ----------------------------------------------------------------------------
// rcac_datapath - history store, averaging, scaling divider and hysteresis
// Works on one item at a time under control of rcac_ctrl.
// ----------------------------------------------------------------------------
module rcac_datapath #(
  parameter int unsigned CHANNELS      = 4,
  parameter int unsigned HISTORY_DEPTH = 8,
  parameter int unsigned RESULT_BITS   = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rcac_pkg::cmd_t          cmd_i,
  output rcac_pkg::status_t       status_o,
  input  logic [1:0]              func_i,
  input  logic [1:0]              channel_i,
  input  logic [15:0]             elapsed_ticks_i,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [11:0]             cfg_data_i,
  output logic [9:0]              result_value_o
);

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned MEM_D  = CHANNELS * HISTORY_DEPTH;
  localparam int unsigned ADDR_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;
  localparam int unsigned SUM_W  = 16 + SLOT_W + 1;
  localparam int unsigned CNT_W  = SLOT_W + 1;
  localparam int unsigned NUM_W  = 16 + RESULT_BITS;
  localparam int unsigned DCNT_W = $clog2(NUM_W + 1);
  localparam logic [RESULT_BITS-1:0] MAX_SCALE = {RESULT_BITS{1'b1}};

  // History store with epoch-free fill: a written-bit per entry
  logic [15:0] hist_mem [MEM_D];
  logic [MEM_D-1:0] hist_vld_q;
  logic [15:0] rd_data_q;
  logic        rd_vld_q;

  logic [SLOT_W-1:0] slot_q;
  logic [15:0]       fs_q   [CHANNELS];
  logic [RESULT_BITS-1:0] held_q [CHANNELS];
  logic [11:0] zoff_q;
  logic [7:0]  hband_q;
  logic        cal_q;

  logic [CH_W-1:0]   ch_q;
  logic [1:0]        func_q;
  logic [CNT_W-1:0]  rd_cnt_q;   // reads issued
  logic [CNT_W-1:0]  acc_cnt_q;  // reads accumulated
  logic [SUM_W-1:0]  sum_q;
  logic [15:0]       val_q;
  logic [15:0]       fsv_q;
  logic [NUM_W-1:0]  num_q;
  logic [16:0]       rem_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [9:0]        res_q;

  logic [CH_W-1:0] ch_in;
  logic            ch_in_ok;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [SUM_W-1:0] avg;
  logic [SUM_W:0]   offs;
  logic [15:0]      clipped;
  logic [16:0]      rem_sh, rem_sub;
  logic [RESULT_BITS-1:0] scaled, held_cur;
  logic [RESULT_BITS+8:0] s_ext, h_ext, b_ext;

  assign ch_in    = channel_i[CH_W-1:0];
  assign ch_in_ok = (32'(channel_i) < CHANNELS);
  assign wr_addr  = ADDR_W'(32'(ch_in) * HISTORY_DEPTH + 32'(slot_q));
  assign rd_addr  = ADDR_W'(32'(ch_q) * HISTORY_DEPTH + 32'(rd_cnt_q));

  // Write the new sample, read history one entry per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && func_i == rcac_pkg::FUNC_SAMPLE && ch_in_ok) begin
      hist_mem[wr_addr] <= elapsed_ticks_i;
    end
    rd_data_q <= hist_mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoff_q  <= rcac_pkg::ZERO_OFFSET_RESET;
      hband_q <= rcac_pkg::HYST_BAND_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rcac_pkg::CFG_ZERO_OFFSET) zoff_q <= cfg_data_i;
      else hband_q <= cfg_data_i[7:0];
    end
  end

  // Average, offset and clip
  assign avg  = SUM_W'(sum_q / HISTORY_DEPTH);
  assign offs = {1'b0, avg} - (SUM_W+1)'(zoff_q);
  assign clipped = offs[SUM_W] ? 16'd0 : 16'(offs[SUM_W-1:0]);

  // Restoring division step
  assign rem_sh  = {rem_q[15:0], num_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, fsv_q};

  assign scaled   = (fsv_q == 16'd0) ? '0 : num_q[RESULT_BITS-1:0];
  assign held_cur = held_q[ch_q];
  assign s_ext = (RESULT_BITS+9)'(scaled);
  assign h_ext = (RESULT_BITS+9)'(held_cur);
  assign b_ext = (RESULT_BITS+9)'(hband_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      slot_q     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        fs_q[i]   <= rcac_pkg::FULL_SCALE_RESET;
        held_q[i] <= '0;
      end
      ch_q       <= '0;
      func_q     <= '0;
      rd_cnt_q   <= '0;
      acc_cnt_q  <= '0;
      sum_q      <= '0;
      val_q      <= '0;
      fsv_q      <= '0;
      num_q      <= '0;
      rem_q      <= '0;
      dcnt_q     <= '0;
      res_q      <= '0;
    end else begin
      rd_vld_q <= hist_vld_q[rd_addr];
      // Capture the item and write history
      if (cmd_i.load) begin
        func_q     <= func_i;
        ch_q       <= ch_in;
        rd_cnt_q   <= '0;
        acc_cnt_q  <= '0;
        sum_q      <= '0;
        res_q      <= '0;
        if (func_i == rcac_pkg::FUNC_SAMPLE && ch_in_ok) begin
          hist_vld_q[wr_addr] <= 1'b1;
          if (32'(ch_in) == CHANNELS - 1) begin
            slot_q <= (32'(slot_q) == HISTORY_DEPTH - 1) ? '0 : slot_q + 1'b1;
          end
        end
        if (func_i == rcac_pkg::FUNC_READ && ch_in_ok) begin
          res_q <= 10'(held_q[ch_in]);
        end
      end
      // Issue reads and accumulate each entry in the cycle after its read
      if (cmd_i.sum_step) begin
        if (32'(rd_cnt_q) < HISTORY_DEPTH) rd_cnt_q <= rd_cnt_q + 1'b1;
        if (rd_cnt_q != '0) begin
          acc_cnt_q <= acc_cnt_q + 1'b1;
          if (rd_vld_q) sum_q <= sum_q + SUM_W'(rd_data_q);
        end
      end
      // Clip or raise full-scale
      if (cmd_i.clip) begin
        if (clipped > fs_q[ch_q]) begin
          if (rcac_pkg::FUNC_SAMPLE == func_q && cal_q) begin
            fs_q[ch_q] <= clipped;
            val_q <= clipped;
            fsv_q <= clipped;
          end else begin
            val_q <= fs_q[ch_q];
            fsv_q <= fs_q[ch_q];
          end
        end else begin
          val_q <= clipped;
          fsv_q <= fs_q[ch_q];
        end
      end
      // Prepare MAX_SCALE * val for division
      if (cmd_i.div_start) begin
        num_q  <= NUM_W'(val_q) * NUM_W'(MAX_SCALE);
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 1'b1;
        if (!rem_sub[16]) begin
          rem_q <= rem_sub;
          num_q <= {num_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          num_q <= {num_q[NUM_W-2:0], 1'b0};
        end
      end
      // Hysteresis on the held result
      if (cmd_i.hyst) begin
        logic [RESULT_BITS-1:0] nh;
        nh = held_cur;
        if (s_ext > h_ext + b_ext || scaled == MAX_SCALE) nh = scaled;
        if (s_ext + b_ext < (RESULT_BITS+9)'(nh) || scaled == '0) nh = scaled;
        held_q[ch_q] <= nh;
        res_q <= 10'(nh);
      end
      // Calibration commands
      if (cmd_i.cal_start) begin
        for (int i = 0; i < CHANNELS; i++) fs_q[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= 1'b0;
    end else if (cmd_i.cal_start) begin
      cal_q <= 1'b1;
    end else if (cmd_i.cal_end) begin
      cal_q <= 1'b0;
    end
  end

  assign status_o.sum_done = (32'(acc_cnt_q) == HISTORY_DEPTH);
  assign status_o.div_done = (32'(dcnt_q) == NUM_W);
  assign result_value_o    = res_q;

endmodule

FILE: sv/rcac_ctrl.sv
// ----------------------------------------------------------------------------
// rcac_ctrl - controller of the RC ADC result conditioner
// Sequences load, summing, clipping, division and hysteresis for one item.
// ----------------------------------------------------------------------------
module rcac_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic              ch_ok_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  rcac_pkg::status_t status_i,
  output rcac_pkg::cmd_t    cmd_o
);

  rcac_pkg::state_e state_q, state_d;
  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rcac_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (func_i == rcac_pkg::FUNC_SAMPLE && ch_ok_i) state_d = rcac_pkg::ST_SUM;
          else state_d = rcac_pkg::ST_OUT;
        end
      end
      rcac_pkg::ST_SUM:   if (status_i.sum_done) state_d = rcac_pkg::ST_SCALE;
      rcac_pkg::ST_SCALE: state_d = rcac_pkg::ST_DIV;
      rcac_pkg::ST_DIV:   if (status_i.div_done) state_d = rcac_pkg::ST_HYST;
      rcac_pkg::ST_HYST:  state_d = rcac_pkg::ST_OUT;
      rcac_pkg::ST_OUT:   if (!out_stall_i) state_d = rcac_pkg::ST_IDLE;
      default:            state_d = rcac_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = (state_q != rcac_pkg::ST_IDLE);
    out_valid_o = (state_q == rcac_pkg::ST_OUT);
    case (state_q)
      rcac_pkg::ST_IDLE: begin
        cmd_o.load      = in_acc;
        cmd_o.cal_start = in_acc && func_i == rcac_pkg::FUNC_CAL_START;
        cmd_o.cal_end   = in_acc && func_i == rcac_pkg::FUNC_CAL_END;
      end
      rcac_pkg::ST_SUM: begin
        cmd_o.sum_step = !status_i.sum_done;
        cmd_o.clip     = status_i.sum_done;
      end
      rcac_pkg::ST_SCALE: cmd_o.div_start = 1'b1;
      rcac_pkg::ST_DIV:   cmd_o.div_step  = !status_i.div_done;
      rcac_pkg::ST_HYST:  cmd_o.hyst      = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcac_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/rc_adc_result_conditioner.sv
// ----------------------------------------------------------------------------
// rc_adc_result_conditioner - multi-channel RC ADC result conditioner
// Sequence: read and calibration items go straight from idle to output; samples
//   pass through the SUM, SCALE, DIV and HYST states, paced by the
//   one-entry-per-cycle history read and the bit-serial restoring divider.
// Throughput: one item at a time, next item accepted once the result is taken.
// Reset: asynchronous active low; history reads as zero until written.
// ----------------------------------------------------------------------------
module rc_adc_result_conditioner #(
  parameter int unsigned CHANNELS      = 4,
  parameter int unsigned HISTORY_DEPTH = 8,
  parameter int unsigned RESULT_BITS   = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [1:0]  channel_i,
  input  logic [15:0] elapsed_ticks_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  result_value_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_data_i
);

  rcac_pkg::cmd_t    cmd;
  rcac_pkg::status_t status;
  logic              ch_ok;

  assign ch_ok = (32'(channel_i) < CHANNELS);

  rcac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .ch_ok_i     (ch_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rcac_datapath #(
    .CHANNELS      (CHANNELS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .RESULT_BITS   (RESULT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .func_i          (func_i),
    .channel_i       (channel_i),
    .elapsed_ticks_i (elapsed_ticks_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .result_value_o  (result_value_o)
  );

`ifndef ASSERT_OFF
  // Input is held off while an item is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during output");
  // A calibration start command answers zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && func_i == rcac_pkg::FUNC_CAL_START) |=>
      (out_valid_o && result_value_o == 10'd0)) else $error("cal start nonzero");
  // At most one of load, summing, division start, division step and hysteresis at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.sum_step, cmd.div_start, cmd.div_step, cmd.hyst}))
    else $error("overlapping commands");
`endif

endmodule
